### rtl/rmsd_pkg.sv
// rmsd_pkg: shared constants, types and commands for the running mean / deviation core
// no dependencies
`timescale 1ns / 1ps

package rmsd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS = 32;
	localparam int SUM_BITS = 48;
	localparam int SUMSQ_BITS = 64;
	localparam int OUT_BITS = 32;
	localparam int ACC_BITS = 96;
	localparam int STEP_BITS = 7;
	localparam int CFG_INDEX_BITS = 8;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHECKPOINT_FIRST = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHECKPOINT_SECOND = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHECKPOINT_THIRD = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHECKPOINT_FOURTH = 8'd3;

	localparam logic [OUT_BITS-1:0] CP_FIRST_RESET = 32'd1;
	localparam logic [OUT_BITS-1:0] CP_SECOND_RESET = 32'd100;
	localparam logic [OUT_BITS-1:0] CP_THIRD_RESET = 32'd1000000;
	localparam logic [OUT_BITS-1:0] CP_FOURTH_RESET = 32'd500000000;

	localparam logic [STEP_BITS-1:0] STEPS_MEAN = 7'd64;
	localparam logic [STEP_BITS-1:0] STEPS_SQUARE = 7'd48;
	localparam logic [STEP_BITS-1:0] STEPS_WIDE = 7'd96;
	localparam logic [STEP_BITS-1:0] STEPS_ROOT = 7'd32;

	typedef enum logic [1:0] {
		OP_DIV = 2'd0,
		OP_SQUARE = 2'd1,
		OP_ROOT = 2'd2
	} op_t;

	typedef struct packed {
		logic start;
		op_t op;
		logic [ACC_BITS-1:0] operand;
		logic [COUNT_BITS-1:0] divisor;
		logic [STEP_BITS-1:0] steps;
	} unit_cmd_t;

	typedef struct packed {
		logic done;
		logic [ACC_BITS-1:0] acc;
		logic [OUT_BITS-1:0] root;
	} unit_status_t;

endpackage

### rtl/rmsd_ifs.sv
// rmsd channel interfaces: sample input, result output, configuration write
// depends on rmsd_pkg
`timescale 1ns / 1ps

interface rmsd_sample_if;
	import rmsd_pkg::*;
	logic valid;
	logic ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface rmsd_result_if;
	import rmsd_pkg::*;
	logic valid;
	logic ready;
	logic signed [OUT_BITS-1:0] mean;
	logic [OUT_BITS-1:0] deviation;
	logic [OUT_BITS-1:0] samples_seen;
	logic checkpoint;
	modport source (output valid, output mean, output deviation, output samples_seen,
		output checkpoint, input ready);
	modport sink (input valid, input mean, input deviation, input samples_seen,
		input checkpoint, output ready);
endinterface

interface rmsd_cfg_if;
	import rmsd_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [OUT_BITS-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/rmsd_serial_unit.sv
// rmsd_serial_unit: bit-serial restoring divider, shift-add squarer and integer square root
// depends on rmsd_pkg
`timescale 1ns / 1ps

module rmsd_serial_unit
	import rmsd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input unit_cmd_t cmd,
	output unit_status_t status
);

	logic [ACC_BITS-1:0] acc_q;
	logic [34:0] rem_q;
	logic [SUM_BITS-1:0] mul_q;
	logic [SUM_BITS-1:0] cand_q;
	logic [OUT_BITS-1:0] root_q;
	logic [COUNT_BITS-1:0] div_q;
	logic [STEP_BITS-1:0] cnt_q;
	op_t op_q;
	logic busy_q;
	logic done_q;

	logic [32:0] dtrial;
	logic dge;
	logic [32:0] ddiff;
	logic [34:0] rtrial;
	logic [34:0] rsub;
	logic rge;

	always_comb begin
		dtrial = {rem_q[31:0], acc_q[ACC_BITS-1]};
		dge = dtrial >= {1'b0, div_q};
		ddiff = dtrial - {1'b0, div_q};
		rtrial = {rem_q[32:0], acc_q[ACC_BITS-1:ACC_BITS-2]};
		rsub = {1'b0, root_q, 2'b01};
		rge = rtrial >= rsub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= OP_DIV;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= cmd.steps;
				op_q <= cmd.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			root_q <= '0;
			div_q <= cmd.divisor;
			mul_q <= cmd.operand[SUM_BITS-1:0];
			cand_q <= cmd.operand[SUM_BITS-1:0];
			acc_q <= (cmd.op == OP_SQUARE) ? '0 : cmd.operand;
		end else if (busy_q) begin
			unique case (op_q)
				OP_DIV: begin
					acc_q <= {acc_q[ACC_BITS-2:0], dge};
					rem_q <= {3'b000, dge ? ddiff[31:0] : dtrial[31:0]};
				end
				OP_SQUARE: begin
					acc_q <= {acc_q[ACC_BITS-2:0], 1'b0}
						+ (mul_q[SUM_BITS-1] ? {{(ACC_BITS-SUM_BITS){1'b0}}, cand_q} : '0);
					mul_q <= {mul_q[SUM_BITS-2:0], 1'b0};
				end
				OP_ROOT: begin
					acc_q <= {acc_q[ACC_BITS-3:0], 2'b00};
					rem_q <= rge ? rtrial - rsub : rtrial;
					root_q <= {root_q[OUT_BITS-2:0], rge};
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign status.done = done_q;
	assign status.acc = acc_q;
	assign status.root = root_q;

endmodule

### rtl/running_mean_std_deviation_core.sv
// running_mean_std_deviation_core: running mean and sample standard deviation, Q16.16
// depends on rmsd_pkg, rmsd_ifs, rmsd_serial_unit
// steps: mean divide, square, two divides, root; only the mean for the first sample
// no sample is taken until the last result has loaded into the output registers
// reset: count, sums and result valid clear; checkpoints return to 1, 100, 1e6, 5e8
`timescale 1ns / 1ps

module running_mean_std_deviation_core
	import rmsd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	rmsd_sample_if.sink sample_ch,
	rmsd_result_if.source result_ch,
	rmsd_cfg_if.sink cfg_ch
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_ACC = 8'b0000_0010,
		S_MDIV = 8'b0000_0100,
		S_SQR = 8'b0000_1000,
		S_QDIV = 8'b0001_0000,
		S_VDIV = 8'b0010_0000,
		S_ROOT = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [COUNT_BITS-1:0] count_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic [SUMSQ_BITS-1:0] sumsq_q;
	logic [OUT_BITS-1:0] cp_q [4];
	logic [OUT_BITS-1:0] mean_q;
	logic [OUT_BITS-1:0] dev_q;
	logic out_valid_q;
	logic signed [OUT_BITS-1:0] out_mean_q;
	logic [OUT_BITS-1:0] out_dev_q;
	logic [OUT_BITS-1:0] out_seen_q;
	logic out_cp_q;

	unit_cmd_t cmd;
	unit_status_t status;

	logic in_xfer;
	logic signed [SAMPLE_BITS-1:0] x;
	logic [2*SAMPLE_BITS-1:0] x_sq;
	logic [SUM_BITS-1:0] mag;
	logic [SUMSQ_BITS-1:0] q_val;
	logic [SUMSQ_BITS-1:0] d_val;
	logic [SUMSQ_BITS-1:0] vs_val;
	logic [SUMSQ_BITS-1:0] mmag;
	logic [OUT_BITS-1:0] mean_val;
	logic out_load;

	rmsd_serial_unit u_unit (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status)
	);

	assign sample_ch.ready = (state_q == S_IDLE);
	assign in_xfer = sample_ch.valid && sample_ch.ready;
	assign x = sample_ch.sample;
	assign x_sq = $unsigned((2*SAMPLE_BITS)'(x) * (2*SAMPLE_BITS)'(x));
	assign cfg_ch.ready = 1'b1;

	always_comb begin
		mag = sum_q[SUM_BITS-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
		mmag = status.acc[SUMSQ_BITS-1:0];
		if (sum_q[SUM_BITS-1]) begin
			mean_val = (mmag > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mmag[OUT_BITS-1:0]);
		end else begin
			mean_val = (mmag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mmag[OUT_BITS-1:0];
		end
		q_val = status.acc[SUMSQ_BITS-1:0];
		d_val = (sumsq_q > q_val) ? sumsq_q - q_val : '0;
		vs_val = (status.acc[ACC_BITS-1:SUMSQ_BITS] != '0) ? '1 : status.acc[SUMSQ_BITS-1:0];
	end

	always_comb begin
		cmd = '0;
		cmd.op = OP_DIV;
		cmd.divisor = count_q;
		unique case (state_q)
			S_ACC: begin
				cmd.start = 1'b1;
				cmd.operand = {mag, 16'h0000, 32'h0000_0000};
				cmd.steps = STEPS_MEAN;
			end
			S_MDIV: begin
				cmd.start = status.done && (count_q != 32'd1);
				cmd.op = OP_SQUARE;
				cmd.operand = {{(ACC_BITS-SUM_BITS){1'b0}}, mag};
				cmd.steps = STEPS_SQUARE;
			end
			S_SQR: begin
				cmd.start = status.done;
				cmd.operand = status.acc;
				cmd.steps = STEPS_WIDE;
			end
			S_QDIV: begin
				cmd.start = status.done;
				cmd.operand = {d_val, 32'h0000_0000};
				cmd.divisor = count_q - 1'b1;
				cmd.steps = STEPS_WIDE;
			end
			S_VDIV: begin
				cmd.start = status.done;
				cmd.op = OP_ROOT;
				cmd.operand = {vs_val, 32'h0000_0000};
				cmd.steps = STEPS_ROOT;
			end
			default: begin
				cmd.start = 1'b0;
			end
		endcase
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			sum_q <= '0;
			sumsq_q <= '0;
			out_valid_q <= 1'b0;
			cp_q[0] <= CP_FIRST_RESET;
			cp_q[1] <= CP_SECOND_RESET;
			cp_q[2] <= CP_THIRD_RESET;
			cp_q[3] <= CP_FOURTH_RESET;
		end else begin
			if (cfg_ch.valid) begin
				unique case (cfg_ch.index)
					CFG_CHECKPOINT_FIRST: cp_q[0] <= cfg_ch.data;
					CFG_CHECKPOINT_SECOND: cp_q[1] <= cfg_ch.data;
					CFG_CHECKPOINT_THIRD: cp_q[2] <= cfg_ch.data;
					CFG_CHECKPOINT_FOURTH: cp_q[3] <= cfg_ch.data;
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_ACC;
						if (count_q != '1) begin
							count_q <= count_q + 1'b1;
							sum_q <= sum_q + SUM_BITS'(x);
							sumsq_q <= sumsq_q + SUMSQ_BITS'(x_sq);
						end
					end
				end
				S_ACC: state_q <= S_MDIV;
				S_MDIV: begin
					if (status.done) begin
						state_q <= (count_q == 32'd1) ? S_DONE : S_SQR;
					end
				end
				S_SQR: if (status.done) state_q <= S_QDIV;
				S_QDIV: if (status.done) state_q <= S_VDIV;
				S_VDIV: if (status.done) state_q <= S_ROOT;
				S_ROOT: if (status.done) state_q <= S_DONE;
				S_DONE: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MDIV && status.done) begin
			mean_q <= mean_val;
			dev_q <= '0;
		end
		if (state_q == S_ROOT && status.done) begin
			dev_q <= status.root;
		end
		if (out_load) begin
			out_mean_q <= mean_q;
			out_dev_q <= dev_q;
			out_seen_q <= count_q;
			out_cp_q <= (count_q == cp_q[0]) || (count_q == cp_q[1])
				|| (count_q == cp_q[2]) || (count_q == cp_q[3]);
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.mean = out_mean_q;
	assign result_ch.deviation = out_dev_q;
	assign result_ch.samples_seen = out_seen_q;
	assign result_ch.checkpoint = out_cp_q;

endmodule

### rtl/rmsd_checker.sv
// rmsd_checker: port-level assertions for the running mean / deviation core
// depends on rmsd_pkg, bound to running_mean_std_deviation_core
`timescale 1ns / 1ps

module rmsd_checker
	import rmsd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [OUT_BITS-1:0] out_seen,
	input logic [OUT_BITS-1:0] out_dev
);

	// held result stays valid, with its deviation stable, until transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_dev))
		else $error("result dropped or changed while stalled");

	// one sample at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while busy");

	// no result can appear right after a sample transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

	// a result always counts at least one sample
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_seen != '0)
		else $error("result with zero count");

endmodule

bind running_mean_std_deviation_core rmsd_checker u_rmsd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(sample_ch.valid),
	.in_ready(sample_ch.ready),
	.out_valid(result_ch.valid),
	.out_ready(result_ch.ready),
	.out_seen(result_ch.samples_seen),
	.out_dev(result_ch.deviation)
);

### tb/testbench.sv
// testbench: self-checking bench for running_mean_std_deviation_core
// depends on rmsd_pkg, rmsd_ifs and the core; predicts mean, deviation, count and checkpoint
`timescale 1ns / 1ps

module testbench;
	import rmsd_pkg::*;

	typedef struct packed {
		logic [OUT_BITS-1:0] mean;
		logic [OUT_BITS-1:0] deviation;
		logic [OUT_BITS-1:0] samples_seen;
		logic checkpoint;
	} stats_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic typed;
		stats_t want;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 16;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 400;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNKNOWN = 8'hFF;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{16'h8000, 1'b1, '{32'h80000000, 32'd0, 32'd1, 1'b1}},
		'{16'h7FFF, 1'b0, '0},
		'{16'h0000, 1'b0, '0},
		'{16'hFFFF, 1'b0, '0},
		'{16'h0001, 1'b0, '0},
		'{16'h5555, 1'b0, '0},
		'{16'hAAAA, 1'b0, '0},
		'{16'h7FFF, 1'b0, '0},
		'{16'h7FFF, 1'b0, '0},
		'{16'h8000, 1'b0, '0},
		'{16'h8000, 1'b0, '0},
		'{16'h0F0F, 1'b0, '0},
		'{16'hF0F0, 1'b0, '0},
		'{16'h0000, 1'b0, '0},
		'{16'h0000, 1'b0, '0},
		'{16'h00FF, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	rmsd_sample_if sample_ch();
	rmsd_result_if result_ch();
	rmsd_cfg_if cfg_ch();

	running_mean_std_deviation_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.cfg_ch(cfg_ch)
	);

	// predictor state
	logic [31:0] cp_first, cp_second, cp_third, cp_fourth;
	logic [COUNT_BITS-1:0] n_samples;
	longint sum_samples;
	logic [SUMSQ_BITS-1:0] sum_squares;

	stats_t expected_stats[$];
	int errors;
	bit idle_on;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [31:0] isqrt(input logic [63:0] v);
		logic [31:0] r;
		logic [31:0] t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (32'd1 << b);
			if ({32'd0, t} * {32'd0, t} <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic stats_t accumulate_sample(input logic [SAMPLE_BITS-1:0] raw);
		longint x;
		logic [63:0] n, mag, mm;
		logic [127:0] q, d, m, v;
		bit neg;
		stats_t s;
		x = longint'($signed(raw));
		if (n_samples != {COUNT_BITS{1'b1}}) begin
			n_samples = n_samples + 1;
			sum_samples = sum_samples + x;
			sum_squares = sum_squares + 64'(x * x);
		end
		n = 64'(n_samples);
		neg = sum_samples < 0;
		mag = neg ? 64'(-sum_samples) : 64'(sum_samples);
		mm = (mag << 16) / n;
		if (neg) begin
			if (mm > 64'h80000000) mm = 64'h80000000;
			s.mean = 32'(-mm);
		end else begin
			if (mm > 64'h7FFFFFFF) mm = 64'h7FFFFFFF;
			s.mean = 32'(mm);
		end
		s.deviation = '0;
		if (n > 1) begin
			q = (128'(mag) * 128'(mag)) / 128'(n);
			d = (128'(sum_squares) > q) ? 128'(sum_squares) - q : '0;
			m = 128'(n - 1);
			if (d / m > 128'hFFFFFFFF)
				v = 128'hFFFFFFFFFFFFFFFF;
			else
				v = (d << 32) / m;
			s.deviation = isqrt(64'(v));
		end
		s.samples_seen = n_samples;
		s.checkpoint = (n_samples == cp_first) || (n_samples == cp_second) ||
			(n_samples == cp_third) || (n_samples == cp_fourth);
		return s;
	endfunction

	// result checker
	always @(posedge clk) begin
		stats_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_stats.size() == 0) begin
				$display("%0t: unexpected result mean=%h dev=%h seen=%0d cp=%b", $time,
					result_ch.mean, result_ch.deviation, result_ch.samples_seen,
					result_ch.checkpoint);
				errors++;
			end else begin
				want = expected_stats.pop_front();
				if (result_ch.mean !== want.mean) begin
					$display("%0t: mean expected %h actual %h", $time, want.mean, result_ch.mean);
					errors++;
				end
				if (result_ch.deviation !== want.deviation) begin
					$display("%0t: deviation expected %h actual %h", $time, want.deviation,
						result_ch.deviation);
					errors++;
				end
				if (result_ch.samples_seen !== want.samples_seen) begin
					$display("%0t: samples_seen expected %0d actual %0d", $time,
						want.samples_seen, result_ch.samples_seen);
					errors++;
				end
				if (result_ch.checkpoint !== want.checkpoint) begin
					$display("%0t: checkpoint expected %b actual %b", $time, want.checkpoint,
						result_ch.checkpoint);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			k = idle_on ? $urandom_range(0, 16) : 0;
			if (k > 0) begin
				result_ch.ready <= 1'b0;
				repeat (k) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] raw, input bit typed,
		input stats_t want);
		int k;
		stats_t s;
		k = idle_on ? $urandom_range(0, 16) : 0;
		if (k > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (k) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= raw;
		do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
		s = accumulate_sample(raw);
		expected_stats.push_back(typed ? want : s);
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_CHECKPOINT_FIRST: cp_first = value;
			CFG_CHECKPOINT_SECOND: cp_second = value;
			CFG_CHECKPOINT_THIRD: cp_third = value;
			CFG_CHECKPOINT_FOURTH: cp_fourth = value;
			default: ;
		endcase
	endtask

	function automatic logic [SAMPLE_BITS-1:0] draw_sample();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3: return SAMPLE_BITS'($signed($urandom_range(0, 16)) - 8);
			4: return 16'h8000 | 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] near_count();
		return n_samples + $urandom_range(1, 100);
	endfunction

	initial begin
		errors = 0;
		idle_on = 1'b1;
		quiet_cycles = 0;
		cp_first = CP_FIRST_RESET;
		cp_second = CP_SECOND_RESET;
		cp_third = CP_THIRD_RESET;
		cp_fourth = CP_FOURTH_RESET;
		n_samples = '0;
		sum_samples = 0;
		sum_squares = '0;
		@(posedge arst_n);
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_sample(DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].want);
		wait_drained();

		// extremes of the checkpoint registers plus an ignored index
		write_reg(CFG_CHECKPOINT_FIRST, 32'd1);
		write_reg(CFG_CHECKPOINT_SECOND, n_samples + 3);
		write_reg(CFG_CHECKPOINT_THIRD, 32'hFFFFFFFF);
		write_reg(CFG_CHECKPOINT_FOURTH, n_samples + 5);
		write_reg(CFG_UNKNOWN, n_samples + 7);
		for (int i = 0; i < 10; i++)
			send_sample(draw_sample(), 1'b0, '0);

		for (int seg = 0; seg < 13; seg++) begin
			wait_drained();
			write_reg(CFG_CHECKPOINT_FIRST, near_count());
			write_reg(CFG_CHECKPOINT_SECOND, near_count());
			write_reg(CFG_CHECKPOINT_THIRD, (seg % 3 == 0) ? 32'hFFFFFFFF : near_count());
			write_reg(CFG_CHECKPOINT_FOURTH, (seg % 4 == 1) ? 32'd1 : near_count());
			if (seg % 5 == 2)
				write_reg(CFG_CHECKPOINT_FIRST + 8'($urandom_range(4, 255)), near_count());
			idle_on = (seg % 3 != 1);
			for (int i = 0; i < 100; i++)
				send_sample(draw_sample(), 1'b0, '0);
		end
		idle_on = 1'b1;

		wait_drained();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
